// File: design/fcc_pkg.sv
// ---------------------------------------------------------------------------
// fcc_pkg
// Shared constants, types and the byte-wide CRC-16/MODBUS update used by
// the four-channel frame block.
// ---------------------------------------------------------------------------
package fcc_pkg;

  localparam int CHANNELS      = 4;
  localparam int VALUE_W       = 16;
  localparam int BYTE_W        = 8;
  localparam int PAYLOAD_BYTES = CHANNELS * VALUE_W / BYTE_W;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
  localparam int CRC_W         = 16;
  localparam int FRAME_LEN     = PAYLOAD_BYTES + CRC_W / BYTE_W;
  localparam int FRAME_W       = FRAME_LEN * BYTE_W;
  localparam int IDX_W         = $clog2(FRAME_LEN);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

  // payload bytes in wire order plus the running crc
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [CRC_W-1:0]     crc;
  } fcc_frame_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] acc;
    acc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// File: design/fcc_crc_pipe.sv
// ---------------------------------------------------------------------------
// fcc_crc_pipe
// Eight-stage crc pipeline: each stage folds one payload byte into the
// crc. Stages advance independently, so bubbles collapse under stall.
// ---------------------------------------------------------------------------
module fcc_crc_pipe
  import fcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAYLOAD_W-1:0] in_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcc_frame_t           out_frame
);

  localparam int STAGES = PAYLOAD_BYTES;

  logic       valid [STAGES];
  fcc_frame_t stage [STAGES];
  logic       ready [STAGES+1];

  // per-stage ready, from the back of the pipe
  always_comb begin
    ready[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        valid[k] <= 1'b0;
      end
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // data path: stage k folds byte k into the crc
  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      stage[0].payload <= in_payload;
      stage[0].crc     <= crc_byte(CRC_INIT, in_payload[BYTE_W-1:0]);
    end
    for (int k = 1; k < STAGES; k++) begin
      if (ready[k] && valid[k-1]) begin
        stage[k].payload <= stage[k-1].payload;
        stage[k].crc     <= crc_byte(stage[k-1].crc,
                                     stage[k-1].payload[k*BYTE_W +: BYTE_W]);
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid[STAGES-1];
  assign out_frame = stage[STAGES-1];

endmodule

// File: design/four_channel_frame_with_crc16.sv
// ---------------------------------------------------------------------------
// four_channel_frame_with_crc16
// Frames four 16-bit channel values as ten bytes ending in a CRC-16/MODBUS.
// ---------------------------------------------------------------------------
// Each accepted word of four channel values leaves as ten frame bytes, one
// per cycle while frame_stall is low: each value low byte then high byte in
// channel order, then the CRC-16/MODBUS (init 0xFFFF, reflected poly 0xA001,
// no final xor) over those eight bytes, low byte first, with last_byte set
// on the tenth byte. The crc is built in an eight-stage pipeline, one byte
// per stage. With the serialiser idle, the first byte of a frame passes
// through the eight pipeline stages, the frame holding register and then the
// output register. Sustained throughput is set by the byte-wide output port;
// the pipeline keeps taking words while a frame is being sent.
// No state persists between words.
module four_channel_frame_with_crc16
  import fcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_stall,
  input  logic [VALUE_W-1:0] value_0,
  input  logic [VALUE_W-1:0] value_1,
  input  logic [VALUE_W-1:0] value_2,
  input  logic [VALUE_W-1:0] value_3,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic [BYTE_W-1:0]  frame_byte,
  output logic               last_byte
);

  logic           pipe_in_ready;
  logic           pipe_valid;
  logic           pipe_ready;
  fcc_frame_t     pipe_frame;

  logic [FRAME_W-1:0] frame;
  logic [IDX_W-1:0]   idx;
  logic               busy;
  logic               load_out;
  logic               frame_done;

  // crc pipeline
  fcc_crc_pipe u_crc_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (value_valid),
    .in_ready   (pipe_in_ready),
    .in_payload ({value_3, value_2, value_1, value_0}),
    .out_valid  (pipe_valid),
    .out_ready  (pipe_ready),
    .out_frame  (pipe_frame)
  );

  assign value_stall = !pipe_in_ready;

  // serialiser handshake
  assign load_out   = !frame_valid || !frame_stall;
  assign frame_done = busy && load_out && (idx == IDX_LAST);
  assign pipe_ready = !busy || frame_done;

  // serialiser control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pipe_valid && pipe_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (frame_done) begin
      busy <= 1'b0;
    end else if (busy && load_out) begin
      idx <= idx + 1'b1;
    end
  end

  // frame holding register
  always_ff @(posedge clk) begin
    if (pipe_valid && pipe_ready) begin
      frame <= {pipe_frame.crc, pipe_frame.payload};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load_out) begin
      frame_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && busy) begin
      frame_byte <= frame[idx*BYTE_W +: BYTE_W];
      last_byte  <= (idx == IDX_LAST);
    end
  end

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= IDX_LAST)
    else $error("frame byte index out of range");

  a_handoff_start: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && pipe_ready) |=> (busy && idx == '0))
    else $error("new frame did not start at byte zero");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> (frame_valid && last_byte))
    else $error("tenth byte not marked last");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (busy && !frame_done) |-> !pipe_ready)
    else $error("pipeline handed over a frame mid-send");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives words of four channel values into four_channel_frame_with_crc16
// and checks every frame byte against a CRC-16/MODBUS frame predicted here,
// with random idle bursts on the input side and random stalls on the output.
// ---------------------------------------------------------------------------
import fcc_pkg::*;

// one expected frame byte
typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic              last;
} frame_entry_t;

// holds the bytes still owed by the block, oldest first
class frame_scoreboard;
  frame_entry_t owed_bytes[$];
  int unsigned  error_count;

  function new();
    error_count = 0;
  endfunction

  // reflected crc over the eight payload bytes, byte 0 in the low bits
  function logic [CRC_W-1:0] modbus_crc(input logic [PAYLOAD_W-1:0] payload);
    logic [CRC_W-1:0] acc;
    acc = CRC_INIT;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      acc = acc ^ {8'h00, payload[BYTE_W*k +: BYTE_W]};
      for (int b = 0; b < BYTE_W; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // an accepted word owes ten bytes: values low byte first, then the crc
  function void note_word(input logic [VALUE_W-1:0] w0, w1, w2, w3);
    logic [PAYLOAD_W-1:0] payload;
    logic [FRAME_W-1:0]   frame;
    frame_entry_t         entry;
    payload = {w3, w2, w1, w0};
    frame   = {modbus_crc(payload), payload};
    for (int k = 0; k < FRAME_LEN; k++) begin
      entry.data = frame[BYTE_W*k +: BYTE_W];
      entry.last = (k == FRAME_LEN - 1);
      owed_bytes.push_back(entry);
    end
  endfunction

  // compare one accepted byte with the oldest one owed
  function void check_byte(input logic [BYTE_W-1:0] data, input logic last);
    frame_entry_t want;
    if (owed_bytes.size() == 0) begin
      $display("%0t: unexpected frame byte %h last %b", $time, data, last);
      error_count++;
    end else begin
      want = owed_bytes.pop_front();
      if (data !== want.data) begin
        $display("%0t: frame_byte expected %h actual %h", $time, want.data, data);
        error_count++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, want.last, last);
        error_count++;
      end
    end
  endfunction

  function int unsigned owed();
    return owed_bytes.size();
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_CHUNKS = 12;
  localparam int CHUNK_WORDS   = 40;
  localparam int DIRECTED      = 14;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               value_valid = 1'b0;
  logic               value_stall;
  logic [VALUE_W-1:0] value_0 = '0;
  logic [VALUE_W-1:0] value_1 = '0;
  logic [VALUE_W-1:0] value_2 = '0;
  logic [VALUE_W-1:0] value_3 = '0;
  logic               frame_valid;
  logic               frame_stall = 1'b0;
  logic [BYTE_W-1:0]  frame_byte;
  logic               last_byte;

  // bit 0: input gaps allowed, bit 1: output stalls allowed
  logic [1:0]         idle_mode = 2'b00;
  int unsigned        stall_left = 0;
  int unsigned        cycle_count = 0;

  frame_scoreboard    board = new();

  four_channel_frame_with_crc16 dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value_0     (value_0),
    .value_1     (value_1),
    .value_2     (value_2),
    .value_3     (value_3),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

  // clock
  always #10 clk = ~clk;

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output stalls in random bursts
  always @(negedge clk) begin
    if (rst || !idle_mode[1]) begin
      stall_left = 0;
      frame_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      frame_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= 1'b0;
    end
  end

  // check every byte taken from the block
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) begin
      board.check_byte(frame_byte, last_byte);
    end
  end

  // offer one word, optionally after an idle burst, and hold it until taken
  task automatic send_word(input logic [VALUE_W-1:0] w0, w1, w2, w3);
    int gap;
    if (idle_mode[0] && $urandom_range(0, 3) == 0) begin
      value_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    value_valid <= 1'b1;
    value_0     <= w0;
    value_1     <= w1;
    value_2     <= w2;
    value_3     <= w3;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    board.note_word(w0, w1, w2, w3);
    @(negedge clk);
  endtask

  // channel value biased towards the corners
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      3:       return ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // directed words: extremes, single bits at each end, byte patterns
  logic [PAYLOAD_W-1:0] corner_words [DIRECTED] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000,
    64'h0001_0001_0001_0001,
    64'h8000_8000_8000_8000,
    64'h00FF_00FF_00FF_00FF,
    64'hFF00_FF00_FF00_FF00,
    64'hAAAA_5555_AAAA_5555,
    64'h5555_AAAA_5555_AAAA,
    64'h0000_FFFF_0000_FFFF,
    64'hFFFF_0000_FFFF_0000,
    64'h3412_7856_BC9A_F0DE,
    64'h7FFF_FFFE_0002_8001
  };

  // stimulus and end of run
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words, back to back with no idling
    for (int i = 0; i < DIRECTED; i++) begin
      send_word(corner_words[i][15:0], corner_words[i][31:16],
                corner_words[i][47:32], corner_words[i][63:48]);
    end

    // random words in chunks; the final chunk runs with no idling
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      idle_mode = (c == RANDOM_CHUNKS - 1) ? 2'b00 : 2'($urandom_range(0, 3));
      for (int i = 0; i < CHUNK_WORDS; i++) begin
        send_word(pick_value(), pick_value(), pick_value(), pick_value());
      end
    end
    value_valid <= 1'b0;

    // drain, then allow for anything stray from the pipeline
    while (board.owed() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (board.owed() != 0) begin
      $display("%0t: %0d frame bytes never arrived", $time, board.owed());
      board.error_count++;
    end
    if (board.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
